// ===== rtl/core/tstm_pkg.sv =====
// Shared types, codes and conversion constants of the temperature threshold monitor.
package tstm_pkg;

	typedef enum logic [1:0] {
		MODE_ADC12       = 2'd0,
		MODE_BYTE        = 2'd1,
		MODE_LINEAR11    = 2'd2,
		MODE_UPPER_BYTE  = 2'd3
	} conv_mode_t;

	typedef enum logic [1:0] {
		CFG_CONVERSION_MODE      = 2'd0,
		CFG_NONCRITICAL_LIMIT    = 2'd1,
		CFG_CRITICAL_LIMIT       = 2'd2,
		CFG_NONRECOVERABLE_LIMIT = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		LVL_NONE    = 2'd0,
		LVL_NONCRIT = 2'd1,
		LVL_CRIT    = 2'd2
	} alarm_level_t;

	typedef enum logic [1:0] {
		EVT_NONE     = 2'd0,
		EVT_ASSERT   = 2'd1,
		EVT_DEASSERT = 2'd2
	} event_kind_t;

	localparam logic [7:0] MASK_NONRECOV = 8'hE0;
	localparam logic [7:0] MASK_CRIT     = 8'hD0;
	localparam logic [7:0] MASK_NONCRIT  = 8'hC8;
	localparam logic [7:0] MASK_CLEAR    = 8'hC0;

	localparam logic [30:0] ADC_GAIN    = 31'd503975;
	localparam logic [30:0] ADC_OFFSET  = 31'd1118822400;
	localparam int          ADC_SHIFT   = 12;
	localparam logic [18:0] BYTE_GAIN   = 19'd1961;
	localparam logic [18:0] BYTE_OFFSET = 19'd50000;
	localparam logic [38:0] RECIP_1000  = 39'd536871;
	localparam int          RECIP_SHIFT = 29;

	typedef struct packed {
		logic [15:0] raw_code;
		logic        sample_present;
		logic        scan_end;
		logic        payload_powered;
	} in_word_t;

	typedef struct packed {
		logic [7:0] reading;
		logic [7:0] state_mask;
		logic       unavailable;
		logic [1:0] event_kind;
		logic [1:0] event_level;
		logic [7:0] event_limit;
		logic       shutdown_request;
	} out_word_t;

	typedef struct packed {
		logic sample_present;
		logic scan_end;
		logic payload_powered;
	} item_flags_t;

	typedef struct packed {
		conv_mode_t mode;
		logic [7:0] noncritical_limit;
		logic [7:0] critical_limit;
		logic [7:0] nonrecoverable_limit;
	} cfg_t;

endpackage

// ===== rtl/core/tstm_cfg.sv =====
// Configuration register file of the temperature threshold monitor.
module tstm_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output tstm_pkg::cfg_t   cfg
);

	tstm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode                 <= tstm_pkg::MODE_ADC12;
			cfg_q.noncritical_limit    <= 8'd255;
			cfg_q.critical_limit       <= 8'd255;
			cfg_q.nonrecoverable_limit <= 8'd255;
		end else if (cfg_valid) begin
			unique case (tstm_pkg::cfg_index_t'(cfg_index))
				tstm_pkg::CFG_CONVERSION_MODE: begin
					cfg_q.mode <= tstm_pkg::conv_mode_t'(cfg_data[1:0]);
				end
				tstm_pkg::CFG_NONCRITICAL_LIMIT: begin
					cfg_q.noncritical_limit <= cfg_data;
				end
				tstm_pkg::CFG_CRITICAL_LIMIT: begin
					cfg_q.critical_limit <= cfg_data;
				end
				tstm_pkg::CFG_NONRECOVERABLE_LIMIT: begin
					cfg_q.nonrecoverable_limit <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/tstm_convert.sv =====
// Three-stage conversion pipeline from raw sensor words to saturated whole degrees.
module tstm_convert (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  sample_valid,
	input  tstm_pkg::in_word_t    sample,
	input  tstm_pkg::conv_mode_t  mode,
	output logic                  item_valid,
	output tstm_pkg::item_flags_t item_flags,
	output logic [7:0]            item_deg
);

	logic                  valid_s1;
	logic [15:0]           raw_s1;
	tstm_pkg::item_flags_t flags_s1;
	tstm_pkg::conv_mode_t  mode_s1;

	logic                  valid_s2;
	tstm_pkg::item_flags_t flags_s2;
	tstm_pkg::conv_mode_t  mode_s2;
	logic [30:0]           adc_prod_s2;
	logic [18:0]           byte_prod_s2;
	logic [7:0]            direct_s2;

	logic                  valid_s3;
	tstm_pkg::item_flags_t flags_s3;
	logic                  use_q_s3;
	logic [9:0]            q_s3;
	logic [7:0]            direct_s3;

	logic [30:0] adc_prod;
	logic [18:0] byte_prod;
	logic [7:0]  direct_deg;
	logic [7:0]  lin_deg;
	logic [10:0] man;
	logic [4:0]  ex;
	logic [4:0]  neg_ex;
	logic [17:0] shl_val;
	logic [9:0]  shr_val;
	logic [30:0] adc_diff;
	logic [18:0] x_val;
	logic [38:0] q_full;

	always_comb begin
		adc_prod  = {19'd0, raw_s1[15:4]} * tstm_pkg::ADC_GAIN;
		byte_prod = {11'd0, raw_s1[7:0]} * tstm_pkg::BYTE_GAIN;
		man       = raw_s1[10:0];
		ex        = raw_s1[15:11];
		neg_ex    = 5'(-ex);
		shl_val   = {8'd0, man[9:0]} << ex[2:0];
		shr_val   = man[9:0] >> neg_ex;
		if (man[10] || (man[9:0] == 10'd0)) begin
			lin_deg = 8'd0;
		end else if (!ex[4]) begin
			if (ex[3] || (shl_val > 18'd255)) begin
				lin_deg = 8'd255;
			end else begin
				lin_deg = shl_val[7:0];
			end
		end else if (shr_val > 10'd255) begin
			lin_deg = 8'd255;
		end else begin
			lin_deg = shr_val[7:0];
		end
		if (mode_s1 == tstm_pkg::MODE_LINEAR11) begin
			direct_deg = lin_deg;
		end else begin
			direct_deg = raw_s1[15:8];
		end
	end

	always_comb begin
		adc_diff = adc_prod_s2 - tstm_pkg::ADC_OFFSET;
		if (mode_s2 == tstm_pkg::MODE_ADC12) begin
			if (adc_prod_s2 > tstm_pkg::ADC_OFFSET) begin
				x_val = 19'(adc_diff >> tstm_pkg::ADC_SHIFT);
			end else begin
				x_val = 19'd0;
			end
		end else if (byte_prod_s2 > tstm_pkg::BYTE_OFFSET) begin
			x_val = byte_prod_s2 - tstm_pkg::BYTE_OFFSET;
		end else begin
			x_val = 19'd0;
		end
		q_full = {20'd0, x_val} * tstm_pkg::RECIP_1000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= sample_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			raw_s1                  <= sample.raw_code;
			flags_s1.sample_present <= sample.sample_present;
			flags_s1.scan_end       <= sample.scan_end;
			flags_s1.payload_powered <= sample.payload_powered;
			mode_s1                 <= mode;

			flags_s2     <= flags_s1;
			mode_s2      <= mode_s1;
			adc_prod_s2  <= adc_prod;
			byte_prod_s2 <= byte_prod;
			direct_s2    <= direct_deg;

			flags_s3  <= flags_s2;
			use_q_s3  <= (mode_s2 == tstm_pkg::MODE_ADC12) || (mode_s2 == tstm_pkg::MODE_BYTE);
			q_s3      <= q_full[tstm_pkg::RECIP_SHIFT +: 10];
			direct_s3 <= direct_s2;
		end
	end

	always_comb begin
		if (!use_q_s3) begin
			item_deg = direct_s3;
		end else if (q_s3 > 10'd255) begin
			item_deg = 8'd255;
		end else begin
			item_deg = q_s3[7:0];
		end
	end

	assign item_valid = valid_s3;
	assign item_flags = flags_s3;

endmodule

// ===== rtl/core/tstm_alarm.sv =====
// Scan maximum, three-threshold alarm machine and result register.
module tstm_alarm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  item_valid,
	input  tstm_pkg::item_flags_t item_flags,
	input  logic [7:0]            item_deg,
	input  tstm_pkg::cfg_t        cfg,
	output logic                  result_valid,
	output tstm_pkg::out_word_t   result
);

	logic [7:0]             scan_max_q;
	logic                   first_scan_q;
	tstm_pkg::alarm_level_t alarm_q;
	logic [7:0]             mask_q;
	logic                   result_valid_q;
	tstm_pkg::out_word_t    result_q;

	logic                   take;
	logic                   eval;
	logic [7:0]             new_max;
	logic                   nr_hit;
	logic                   crit_hi;
	logic                   nc_hi;
	tstm_pkg::alarm_level_t alarm_d;
	logic [7:0]             mask_d;
	tstm_pkg::out_word_t    result_d;

	always_comb begin
		take = item_valid && item_flags.payload_powered && item_flags.sample_present;
		if (take && (item_deg >= scan_max_q)) begin
			new_max = item_deg;
		end else begin
			new_max = scan_max_q;
		end
		eval    = item_flags.payload_powered && !first_scan_q;
		nr_hit  = new_max >= cfg.nonrecoverable_limit;
		crit_hi = new_max >= cfg.critical_limit;
		nc_hi   = new_max >= cfg.noncritical_limit;
	end

	always_comb begin
		alarm_d = alarm_q;
		if (eval && !nr_hit) begin
			priority if ((alarm_q == tstm_pkg::LVL_NONE) && crit_hi) begin
				alarm_d = tstm_pkg::LVL_CRIT;
			end else if ((alarm_q == tstm_pkg::LVL_CRIT) && !crit_hi) begin
				alarm_d = tstm_pkg::LVL_NONE;
			end else if ((alarm_q == tstm_pkg::LVL_NONE) && nc_hi) begin
				alarm_d = tstm_pkg::LVL_NONCRIT;
			end else if ((alarm_q == tstm_pkg::LVL_NONCRIT) && !nc_hi) begin
				alarm_d = tstm_pkg::LVL_NONE;
			end else begin
				alarm_d = alarm_q;
			end
		end
	end

	always_comb begin
		mask_d                    = mask_q;
		result_d.reading          = new_max;
		result_d.unavailable      = 1'b0;
		result_d.event_kind       = tstm_pkg::EVT_NONE;
		result_d.event_level      = tstm_pkg::LVL_NONE;
		result_d.event_limit      = 8'd0;
		result_d.shutdown_request = 1'b0;
		if (!item_flags.payload_powered) begin
			mask_d               = 8'd0;
			result_d.reading     = 8'd0;
			result_d.unavailable = 1'b1;
		end else if (eval) begin
			priority if (nr_hit) begin
				mask_d                    = tstm_pkg::MASK_NONRECOV;
				result_d.shutdown_request = 1'b1;
			end else if ((alarm_q == tstm_pkg::LVL_NONE) && crit_hi) begin
				mask_d               = tstm_pkg::MASK_CRIT;
				result_d.event_kind  = tstm_pkg::EVT_ASSERT;
				result_d.event_level = tstm_pkg::LVL_CRIT;
				result_d.event_limit = cfg.critical_limit;
			end else if ((alarm_q == tstm_pkg::LVL_CRIT) && !crit_hi) begin
				mask_d               = tstm_pkg::MASK_CLEAR;
				result_d.event_kind  = tstm_pkg::EVT_DEASSERT;
				result_d.event_level = tstm_pkg::LVL_CRIT;
				result_d.event_limit = cfg.critical_limit;
			end else if ((alarm_q == tstm_pkg::LVL_NONE) && nc_hi) begin
				mask_d               = tstm_pkg::MASK_NONCRIT;
				result_d.event_kind  = tstm_pkg::EVT_ASSERT;
				result_d.event_level = tstm_pkg::LVL_NONCRIT;
				result_d.event_limit = cfg.noncritical_limit;
			end else if ((alarm_q == tstm_pkg::LVL_NONCRIT) && !nc_hi) begin
				mask_d               = tstm_pkg::MASK_CLEAR;
				result_d.event_kind  = tstm_pkg::EVT_DEASSERT;
				result_d.event_level = tstm_pkg::LVL_NONCRIT;
				result_d.event_limit = cfg.noncritical_limit;
			end else begin
				mask_d = mask_q;
			end
		end
		result_d.state_mask = mask_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_max_q     <= 8'd0;
			first_scan_q   <= 1'b1;
			alarm_q        <= tstm_pkg::LVL_NONE;
			mask_q         <= 8'd0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= item_valid && item_flags.scan_end;
			if (item_valid) begin
				if (item_flags.scan_end) begin
					scan_max_q <= 8'd0;
					mask_q     <= mask_d;
					alarm_q    <= alarm_d;
					if (item_flags.payload_powered) begin
						first_scan_q <= 1'b0;
					end
				end else begin
					scan_max_q <= new_max;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_shutdown_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.shutdown_request |->
			(result_q.state_mask == tstm_pkg::MASK_NONRECOV) &&
			(result_q.event_kind == tstm_pkg::EVT_NONE))
		else $error("Shutdown word carries an event or a wrong mask.");

	a_unavailable_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.unavailable |->
			(result_q.reading == 8'd0) && (result_q.state_mask == 8'd0) &&
			!result_q.shutdown_request)
		else $error("Unavailable word reports a reading or a mask.");

	a_crit_assert_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.event_kind == tstm_pkg::EVT_ASSERT) &&
			(result_q.event_level == tstm_pkg::LVL_CRIT) |->
			(result_q.state_mask == tstm_pkg::MASK_CRIT))
		else $error("Critical assertion without the critical mask.");

	a_no_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.event_kind == tstm_pkg::EVT_NONE) |->
			(result_q.event_level == tstm_pkg::LVL_NONE) && (result_q.event_limit == 8'd0))
		else $error("Word without an event reports a level or a limit.");

endmodule

// ===== rtl/core/temp_sensor_threshold_monitor_top.sv =====
// Top level of the temperature threshold monitor.
// A result word is registered in the alarm stage once the scan-end word has passed the three conversion stages.
// Throughput: one sample word per cycle through the three conversion stages and the alarm stage, unless held.
// The whole pipeline holds only while a result word waits and result_ready is low.
// Reset is asynchronous, active low: limits return to 255, mode to the ADC code format,
// the alarm to none, and the first scan after reset reports without events.
module temp_sensor_threshold_monitor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  tstm_pkg::in_word_t  sample,
	output logic                result_valid,
	input  logic                result_ready,
	output tstm_pkg::out_word_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	tstm_pkg::cfg_t        cfg;
	logic                  advance;
	logic                  item_valid;
	tstm_pkg::item_flags_t item_flags;
	logic [7:0]            item_deg;

	assign advance      = !result_valid || result_ready;
	assign sample_ready = advance;

	tstm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tstm_convert u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.sample_valid (sample_valid),
		.sample       (sample),
		.mode         (cfg.mode),
		.item_valid   (item_valid),
		.item_flags   (item_flags),
		.item_deg     (item_deg)
	);

	tstm_alarm u_alarm (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item_valid   (item_valid),
		.item_flags   (item_flags),
		.item_deg     (item_deg),
		.cfg          (cfg),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== bench/tb_temp_sensor_threshold_monitor_top.sv =====
// Self-checking testbench of the temperature threshold monitor: directed and random scans.
module tb_temp_sensor_threshold_monitor_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 20;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 100;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	tstm_pkg::in_word_t   sample = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	tstm_pkg::out_word_t  result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	tstm_pkg::cfg_index_t cfg_index = tstm_pkg::CFG_CONVERSION_MODE;
	logic [7:0]           cfg_data = '0;

	tstm_pkg::in_word_t   pending_words[$];
	tstm_pkg::out_word_t  expected_reports[$];
	int unsigned          send_hold = 0;
	int unsigned          recv_hold = 0;
	bit                   steady_tail = 1'b0;
	int                   mismatches = 0;
	int                   cycle_count = 0;
	int                   queued_words = 0;

	tstm_pkg::conv_mode_t   cur_mode = tstm_pkg::MODE_ADC12;
	logic [7:0]             lim_noncrit = 8'd255;
	logic [7:0]             lim_crit = 8'd255;
	logic [7:0]             lim_nonrec = 8'd255;
	logic [7:0]             scan_peak = '0;
	bit                     first_scan = 1'b1;
	tstm_pkg::alarm_level_t alarm_now = tstm_pkg::LVL_NONE;
	logic [7:0]             mask_now = '0;

	temp_sensor_threshold_monitor_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [7:0] saturate(longint d);
		if (d <= 0)
			return 8'd0;
		if (d > 255)
			return 8'd255;
		return d[7:0];
	endfunction

	function automatic logic [7:0] to_degrees(logic [15:0] raw, tstm_pkg::conv_mode_t m);
		longint num;
		longint man;
		int     ex;
		case (m)
			tstm_pkg::MODE_ADC12: begin
				num = longint'(raw[15:4]) * 64'sd503975 - 64'sd1118822400;
				if (num <= 0)
					return 8'd0;
				return saturate(num / 64'sd4096000);
			end
			tstm_pkg::MODE_BYTE: begin
				num = longint'(raw[7:0]) * 64'sd1961 - 64'sd50000;
				if (num <= 0)
					return 8'd0;
				return saturate(num / 64'sd1000);
			end
			tstm_pkg::MODE_LINEAR11: begin
				man = longint'($signed(raw[10:0]));
				ex  = int'($signed(raw[15:11]));
				if (man <= 0)
					return 8'd0;
				if (ex >= 0)
					return saturate(man << ex);
				return saturate(man >>> (-ex));
			end
			default: return raw[15:8];
		endcase
	endfunction

	function automatic void predict_sample(tstm_pkg::in_word_t w);
		tstm_pkg::out_word_t r;
		logic [7:0]          deg;
		r = '0;
		if (w.payload_powered && w.sample_present) begin
			deg = to_degrees(w.raw_code, cur_mode);
			if (deg >= scan_peak)
				scan_peak = deg;
		end
		if (!w.scan_end)
			return;
		if (!w.payload_powered) begin
			r.unavailable = 1'b1;
			mask_now = '0;
			scan_peak = '0;
		end else begin
			r.reading = scan_peak;
			scan_peak = '0;
			if (first_scan) begin
				first_scan = 1'b0;
			end else if (r.reading >= lim_nonrec) begin
				mask_now = tstm_pkg::MASK_NONRECOV;
				r.shutdown_request = 1'b1;
			end else if (alarm_now == tstm_pkg::LVL_NONE && r.reading >= lim_crit) begin
				mask_now = tstm_pkg::MASK_CRIT;
				r.event_kind = tstm_pkg::EVT_ASSERT;
				r.event_level = tstm_pkg::LVL_CRIT;
				r.event_limit = lim_crit;
				alarm_now = tstm_pkg::LVL_CRIT;
			end else if (alarm_now == tstm_pkg::LVL_CRIT && r.reading < lim_crit) begin
				mask_now = tstm_pkg::MASK_CLEAR;
				r.event_kind = tstm_pkg::EVT_DEASSERT;
				r.event_level = tstm_pkg::LVL_CRIT;
				r.event_limit = lim_crit;
				alarm_now = tstm_pkg::LVL_NONE;
			end else if (alarm_now == tstm_pkg::LVL_NONE && r.reading >= lim_noncrit) begin
				mask_now = tstm_pkg::MASK_NONCRIT;
				r.event_kind = tstm_pkg::EVT_ASSERT;
				r.event_level = tstm_pkg::LVL_NONCRIT;
				r.event_limit = lim_noncrit;
				alarm_now = tstm_pkg::LVL_NONCRIT;
			end else if (alarm_now == tstm_pkg::LVL_NONCRIT && r.reading < lim_noncrit) begin
				mask_now = tstm_pkg::MASK_CLEAR;
				r.event_kind = tstm_pkg::EVT_DEASSERT;
				r.event_level = tstm_pkg::LVL_NONCRIT;
				r.event_limit = lim_noncrit;
				alarm_now = tstm_pkg::LVL_NONE;
			end
		end
		r.state_mask = mask_now;
		expected_reports.push_back(r);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch in %s: got %0d, expected %0d, at %0t ns", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin : feed
		tstm_pkg::in_word_t next_word;
		logic               next_valid;
		if (arst_n) begin
			if (sample_valid && sample_ready)
				predict_sample(sample);
			next_valid = sample_valid && !sample_ready;
			next_word  = sample;
			if (!next_valid) begin
				if (send_hold != 0) begin
					send_hold <= send_hold - 1;
				end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
					send_hold <= $urandom_range(0, 2);
				end else if (pending_words.size() != 0) begin
					next_word  = pending_words.pop_front();
					next_valid = 1'b1;
				end
			end
			sample_valid <= next_valid;
			sample       <= next_word;
		end
	end

	always @(posedge clk) begin : watch
		tstm_pkg::out_word_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("result word with none expected", result, 0);
				end else begin
					want = expected_reports.pop_front();
					if (result.reading !== want.reading)
						report_mismatch("reading", result.reading, want.reading);
					if (result.state_mask !== want.state_mask)
						report_mismatch("state_mask", result.state_mask, want.state_mask);
					if (result.unavailable !== want.unavailable)
						report_mismatch("unavailable", result.unavailable, want.unavailable);
					if (result.event_kind !== want.event_kind)
						report_mismatch("event_kind", result.event_kind, want.event_kind);
					if (result.event_level !== want.event_level)
						report_mismatch("event_level", result.event_level, want.event_level);
					if (result.event_limit !== want.event_limit)
						report_mismatch("event_limit", result.event_limit, want.event_limit);
					if (result.shutdown_request !== want.shutdown_request)
						report_mismatch("shutdown_request", result.shutdown_request,
							want.shutdown_request);
				end
			end
			if (recv_hold != 0) begin
				recv_hold    <= recv_hold - 1;
				result_ready <= 1'b0;
			end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
				recv_hold    <= $urandom_range(0, 2);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_word(logic [15:0] raw, bit present, bit last, bit powered);
		tstm_pkg::in_word_t w;
		w.raw_code        = raw;
		w.sample_present  = present;
		w.scan_end        = last;
		w.payload_powered = powered;
		pending_words.push_back(w);
		queued_words++;
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || sample_valid || expected_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(tstm_pkg::cfg_index_t idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			tstm_pkg::CFG_CONVERSION_MODE:      cur_mode = tstm_pkg::conv_mode_t'(val[1:0]);
			tstm_pkg::CFG_NONCRITICAL_LIMIT:    lim_noncrit = val;
			tstm_pkg::CFG_CRITICAL_LIMIT:       lim_crit = val;
			tstm_pkg::CFG_NONRECOVERABLE_LIMIT: lim_nonrec = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(tstm_pkg::conv_mode_t m, int nc, int c, int nr);
		settle();
		write_reg(tstm_pkg::CFG_CONVERSION_MODE, 8'(m));
		write_reg(tstm_pkg::CFG_NONCRITICAL_LIMIT, 8'(nc));
		write_reg(tstm_pkg::CFG_CRITICAL_LIMIT, 8'(c));
		write_reg(tstm_pkg::CFG_NONRECOVERABLE_LIMIT, 8'(nr));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] encode_degrees(int deg);
		longint code;
		int     ex;
		int     man;
		case (cur_mode)
			tstm_pkg::MODE_ADC12: begin
				code = (longint'(deg) * 1000 + 273150) * 4096 / 503975 + $urandom_range(0, 1);
				if (code > 4095)
					code = 4095;
				return {code[11:0], 4'($urandom)};
			end
			tstm_pkg::MODE_BYTE: begin
				code = longint'(deg + 50) * 1000 / 1961 + $urandom_range(0, 1);
				if (code > 255)
					code = 255;
				return {8'($urandom), code[7:0]};
			end
			tstm_pkg::MODE_LINEAR11: begin
				ex = int'($urandom_range(0, 3)) - 2;
				man = (ex >= 0) ? (deg >> ex) : (deg << (-ex));
				return {5'(ex), 11'(man)};
			end
			default: return {8'(deg), 8'($urandom)};
		endcase
	endfunction

	task automatic queue_scan();
		int n;
		int peak;
		int deg;
		n = $urandom_range(1, 6);
		case ($urandom_range(0, 4))
			0: peak = $urandom_range(0, 255);
			1: peak = int'(lim_noncrit) + int'($urandom_range(0, 10)) - 5;
			2: peak = int'(lim_crit) + int'($urandom_range(0, 10)) - 5;
			3: peak = int'(lim_nonrec) + int'($urandom_range(0, 10)) - 5;
			default: peak = $urandom_range(0, 40);
		endcase
		if (peak < 0)
			peak = 0;
		if (peak > 255)
			peak = 255;
		for (int i = 0; i < n; i++) begin
			deg = (i == n - 1) ? peak : peak - int'($urandom_range(0, 12));
			if (deg < 0)
				deg = 0;
			queue_word(($urandom_range(0, 4) == 0) ? 16'($urandom) : encode_degrees(deg),
				$urandom_range(0, 9) != 0, i == n - 1, $urandom_range(0, 19) != 0);
		end
	endtask

	initial begin
		int nc;
		int c;
		int nr;
		int mark;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_regs(tstm_pkg::MODE_UPPER_BYTE, 50, 100, 200);
		queue_word({8'd10, 8'h00}, 1, 1, 1);
		queue_word({8'd250, 8'h00}, 0, 0, 1);
		queue_word({8'd20, 8'h7F}, 1, 1, 1);
		queue_word({8'd60, 8'h00}, 1, 1, 1);
		queue_word({8'd120, 8'h00}, 1, 1, 1);
		queue_word({8'd30, 8'h00}, 1, 1, 1);
		queue_word({8'd150, 8'h00}, 1, 1, 1);
		queue_word({8'd60, 8'h00}, 1, 1, 1);
		queue_word({8'd210, 8'h00}, 1, 1, 1);
		queue_word({8'd255, 8'h00}, 1, 0, 0);
		queue_word({8'd5, 8'h00}, 1, 1, 1);
		queue_word({8'd100, 8'h00}, 1, 1, 0);
		queue_word(16'hFFFF, 1, 1, 1);
		queue_word(16'h0000, 1, 1, 1);

		set_regs(tstm_pkg::MODE_ADC12, 0, 0, 0);
		queue_word(16'h0000, 1, 1, 1);
		queue_word(16'hFFFF, 1, 1, 1);
		set_regs(tstm_pkg::MODE_BYTE, 255, 255, 255);
		queue_word(16'h0000, 1, 1, 1);
		queue_word(16'hFFFF, 1, 1, 1);
		set_regs(tstm_pkg::MODE_LINEAR11, 40, 120, 250);
		queue_word(16'h03FF, 1, 1, 1);
		queue_word(16'h7801, 1, 1, 1);
		queue_word(16'h83FF, 1, 1, 1);
		queue_word(16'hFA00, 1, 1, 1);
		queue_word(16'h0400, 1, 1, 1);
		queue_word(16'hFFFF, 1, 1, 1);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					nc = 0;
					c = 0;
					nr = 0;
				end
				1: begin
					nc = 255;
					c = 255;
					nr = 255;
				end
				2, 3: begin
					nc = $urandom_range(0, 255);
					c = $urandom_range(0, 255);
					nr = $urandom_range(0, 255);
				end
				default: begin
					nc = $urandom_range(10, 150);
					c = nc + int'($urandom_range(0, 60));
					nr = c + int'($urandom_range(0, 60));
					if (c > 255)
						c = 255;
					if (nr > 255)
						nr = 255;
				end
			endcase
			set_regs(tstm_pkg::conv_mode_t'(p % 4), nc, c, nr);
			if (p == 7)
				steady_tail = 1'b1;
			mark = queued_words;
			while (queued_words - mark < RANDOM_WORDS)
				queue_scan();
		end

		settle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
